// ----- rtl/imu_bcc_pkg.sv -----
// Shared types, codes and constants for the IMU bias calibrate and correct block.
`timescale 1ns / 1ps

package imu_bcc_pkg;

  // Axis and accumulator widths
  localparam int AXIS_W = 16;
  localparam int SUM_W  = 22;
  localparam int GRAV_W = 15;

  // Function codes carried on the input tuser
  localparam logic [1:0] FUNC_MEAS   = 2'd0;
  localparam logic [1:0] FUNC_CAL    = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // Sensor tags
  localparam logic [1:0] SENS_GYRO  = 2'd0;
  localparam logic [1:0] SENS_ACCEL = 2'd1;
  localparam logic [1:0] SENS_MAG   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_OFFSETS = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  // Accelerometer full-scale codes
  localparam logic [2:0] RANGE_2G  = 3'd0;
  localparam logic [2:0] RANGE_4G  = 3'd1;
  localparam logic [2:0] RANGE_6G  = 3'd2;
  localparam logic [2:0] RANGE_8G  = 3'd3;
  localparam logic [2:0] RANGE_16G = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;
    logic cal_upd;
    logic div_start;
    logic load_sample;
    logic load_empty;
    logic load_offsets;
    logic clear_sums;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [1:0] func;
    logic       finish_empty;
    logic       slot_free;
    logic       div_done;
  } status_t;

  // One g in counts for the selected full scale; unknown codes act as 16g
  function automatic logic [GRAV_W-1:0] gravity(input logic [2:0] range);
    logic [GRAV_W-1:0] g;
    case (range)
      RANGE_2G:  g = GRAV_W'(16384);
      RANGE_4G:  g = GRAV_W'(8192);
      RANGE_6G:  g = GRAV_W'(5461);
      RANGE_8G:  g = GRAV_W'(4096);
      RANGE_16G: g = GRAV_W'(2048);
      default:   g = GRAV_W'(2048);
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/imu_bcc_ctrl.sv -----
// Sequencing state machine for the IMU bias calibrate and correct block.
`timescale 1ns / 1ps

module imu_bcc_ctrl
  import imu_bcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts.func)
          FUNC_MEAS: begin
            if (sts.slot_free) state_next = ST_IDLE;
          end
          FUNC_CAL: state_next = ST_IDLE;
          FUNC_FINISH: begin
            if (!sts.finish_empty) state_next = ST_DIV;
            else if (sts.slot_free) state_next = ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (sts.div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (sts.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.accept = 1'b1;
      ST_EXEC: begin
        case (sts.func)
          FUNC_MEAS: cmd.load_sample = sts.slot_free;
          FUNC_CAL:  cmd.cal_upd = 1'b1;
          FUNC_FINISH: begin
            if (!sts.finish_empty) begin
              cmd.div_start = 1'b1;
            end else if (sts.slot_free) begin
              cmd.load_empty = 1'b1;
              cmd.clear_sums = 1'b1;
            end
          end
          default: cmd = '0;
        endcase
      end
      ST_DIV: cmd = '0;
      ST_FIN: begin
        if (sts.slot_free) begin
          cmd.load_offsets = 1'b1;
          cmd.clear_sums   = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/imu_bcc_dp.sv -----
// Datapath: input latch, accumulators, offset store, shared divider, output register.
`timescale 1ns / 1ps

module imu_bcc_dp
  import imu_bcc_pkg::*;
#(
  parameter int MAX_SAMPLES = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           sts,
  // input item
  input  logic              in_valid,
  input  logic [1:0]        in_func,
  input  logic [1:0]        in_sel,
  input  logic [AXIS_W-1:0] in_x,
  input  logic [AXIS_W-1:0] in_y,
  input  logic [AXIS_W-1:0] in_z,
  // configuration
  input  logic              cfg_we,
  input  logic [2:0]        cfg_range,
  // result item
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [1:0]        out_sens,
  output logic [AXIS_W-1:0] out_x,
  output logic [AXIS_W-1:0] out_y,
  output logic [AXIS_W-1:0] out_z
);

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int DIVC_W  = $clog2(SUM_W);
  localparam int NAX     = 3;

  // latched item
  logic [1:0]        func_q;
  logic [1:0]        sel_q;
  logic [AXIS_W-1:0] ax_q [NAX];

  logic [2:0]        range;
  logic [SUM_W-1:0]  sum [NAX];
  logic [CNT_W-1:0]  count;
  logic              cal_sens;
  logic [AXIS_W-1:0] gyro_off [NAX];
  logic [AXIS_W-1:0] acc_off  [NAX];

  // divider lanes
  logic [SUM_W-1:0]  dq   [NAX];
  logic [CNT_W-1:0]  rem  [NAX];
  logic              neg  [NAX];
  logic [CNT_W:0]    trial [NAX];
  logic              div_busy;
  logic [DIVC_W-1:0] div_cnt;

  logic [SUM_W-1:0]  addend [NAX];
  logic [SUM_W-1:0]  quot   [NAX];
  logic [AXIS_W-1:0] sel_off [NAX];
  logic              restart;
  logic              take;
  logic              cal_ok;
  logic              out_load;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_valid) begin
      func_q   <= in_func;
      sel_q    <= in_sel;
      ax_q[0]  <= in_x;
      ax_q[1]  <= in_y;
      ax_q[2]  <= in_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range <= RANGE_4G;
    end else if (cfg_we) begin
      range <= cfg_range;
    end
  end

  // Sample terms; accelerometer z carries one g
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      addend[i] = {{(SUM_W-AXIS_W){ax_q[i][AXIS_W-1]}}, ax_q[i]};
    end
    if (sel_q == SENS_ACCEL) begin
      addend[2] = addend[2] + SUM_W'(gravity(range));
    end
  end

  assign cal_ok  = (sel_q == SENS_GYRO) || (sel_q == SENS_ACCEL);
  assign restart = sel_q[0] != cal_sens;
  assign take    = restart || (count < CNT_W'(MAX_SAMPLES));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NAX; i++) sum[i] <= '0;
      count    <= '0;
      cal_sens <= 1'b0;
    end else if (cmd.clear_sums) begin
      for (int i = 0; i < NAX; i++) sum[i] <= '0;
      count <= '0;
    end else if (cmd.cal_upd && cal_ok) begin
      cal_sens <= sel_q[0];
      if (restart) begin
        for (int i = 0; i < NAX; i++) sum[i] <= addend[i];
        count <= CNT_W'(1);
      end else if (take) begin
        for (int i = 0; i < NAX; i++) sum[i] <= sum[i] + addend[i];
        count <= count + CNT_W'(1);
      end
    end
  end

  // Restoring division of |sum| by count, one quotient bit per cycle per lane
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      trial[i] = {rem[i], dq[i][SUM_W-1]};
      quot[i]  = neg[i] ? (~dq[i] + SUM_W'(1)) : dq[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + DIVC_W'(1);
      if (div_cnt == DIVC_W'(SUM_W - 1)) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      for (int i = 0; i < NAX; i++) begin
        neg[i] <= sum[i][SUM_W-1];
        dq[i]  <= sum[i][SUM_W-1] ? (~sum[i] + SUM_W'(1)) : sum[i];
        rem[i] <= '0;
      end
    end else if (div_busy) begin
      for (int i = 0; i < NAX; i++) begin
        if (trial[i] >= {1'b0, count}) begin
          rem[i] <= CNT_W'(trial[i] - {1'b0, count});
          dq[i]  <= {dq[i][SUM_W-2:0], 1'b1};
        end else begin
          rem[i] <= trial[i][CNT_W-1:0];
          dq[i]  <= {dq[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // Offset store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NAX; i++) begin
        gyro_off[i] <= '0;
        acc_off[i]  <= '0;
      end
    end else if (cmd.load_offsets) begin
      for (int i = 0; i < NAX; i++) begin
        if (sel_q == SENS_GYRO) gyro_off[i] <= quot[i][AXIS_W-1:0];
        else                    acc_off[i]  <= quot[i][AXIS_W-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      case (sel_q)
        SENS_GYRO:  sel_off[i] = gyro_off[i];
        SENS_ACCEL: sel_off[i] = acc_off[i];
        default:    sel_off[i] = '0;
      endcase
    end
  end

  // Output register
  assign out_load = cmd.load_sample || cmd.load_empty || cmd.load_offsets;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      out_kind <= KIND_SAMPLE;
      out_sens <= sel_q;
      out_x    <= ax_q[0] - sel_off[0];
      out_y    <= ax_q[1] - sel_off[1];
      out_z    <= ax_q[2] - sel_off[2];
    end else if (cmd.load_empty) begin
      out_kind <= KIND_EMPTY;
      out_sens <= sel_q;
      out_x    <= '0;
      out_y    <= '0;
      out_z    <= '0;
    end else if (cmd.load_offsets) begin
      out_kind <= KIND_OFFSETS;
      out_sens <= sel_q;
      out_x    <= quot[0][AXIS_W-1:0];
      out_y    <= quot[1][AXIS_W-1:0];
      out_z    <= quot[2][AXIS_W-1:0];
    end
  end

  assign sts.func         = func_q;
  assign sts.finish_empty = (count == '0) || !cal_ok || restart;
  assign sts.slot_free    = !out_valid || out_ready;
  assign sts.div_done     = div_busy && (div_cnt == DIVC_W'(SUM_W - 1));

endmodule

// ----- rtl/imu_bias_calibrate_and_correct.sv -----
// Top level of the IMU bias calibrate and correct block.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one three-axis reading per transfer, tagged in tuser with a
//   function (measure, calibration sample, finish) and a sensor. m_axis carries
//   corrected samples, freshly installed offsets, or an "empty calibration"
//   report. cfg is a plain write channel for the accelerometer range code,
//   always ready; write it only while the block is idle.
// Timing:
//   Each item is taken in the idle state (s_axis_tready high) and then run in the
//   execute state, so the block takes no new item until the last one is done.
//   A measurement result is loaded into the output register from the execute
//   state once that register is free, and can then leave on m_axis. A finish
//   item with samples runs the shared 22-step restoring divider (all three axes
//   side by side, one quotient bit per cycle); its offsets load from the finish
//   state once the output register is free, and only then is the next item taken.
// Stall: the result sits in an output register; the next item is taken while it
//   waits, and only an item that needs the output register waits for it.
// Reset: sums, count, offsets cleared, range code back to 4g, output empty.

module imu_bias_calibrate_and_correct
  import imu_bcc_pkg::*;
#(
  parameter int MAX_SAMPLES = 31
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // axis_x_in, axis_y_in, axis_z_in
  input  logic [3:0]  s_axis_tuser,   // func, sensor_sel
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // axis_x_out, axis_y_out, axis_z_out
  output logic [3:0]  m_axis_tuser,   // result_kind, sensor_out
  // range register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = cmd.accept;

  imu_bcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  imu_bcc_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (s_axis_tvalid),
    .in_func   (s_axis_tuser[1:0]),
    .in_sel    (s_axis_tuser[3:2]),
    .in_x      (s_axis_tdata[15:0]),
    .in_y      (s_axis_tdata[31:16]),
    .in_z      (s_axis_tdata[47:32]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_range (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_kind  (m_axis_tuser[1:0]),
    .out_sens  (m_axis_tuser[3:2]),
    .out_x     (m_axis_tdata[15:0]),
    .out_y     (m_axis_tdata[31:16]),
    .out_z     (m_axis_tdata[47:32])
  );

  // A result is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_sample || cmd.load_empty || cmd.load_offsets) |-> sts.slot_free)
    else $error("output register loaded while holding an untaken result");

  // At most one result load per cycle
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load_sample, cmd.load_empty, cmd.load_offsets}) <= 1)
    else $error("more than one result load in a cycle");

  // After a transfer in, the block is busy executing that item
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new item taken while previous item still executing");

  // A divider start is not followed directly by another start or by an offset install
  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !cmd.div_start && !cmd.load_offsets)
    else $error("divider start sequence broken");

endmodule
